/* rtl/sms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

    localparam int DEF_TOTAL_SIZE = 1024;
    localparam int DEF_NUM_STACKS = 4;

    localparam int OP_W   = 2;
    localparam int SEL_W  = 4;
    localparam int DATA_W = 32;
    localparam int FILL_W = 11;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_TOP  = 2'd2,
        OP_SIZE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

endpackage

`default_nettype wire

/* rtl/sms_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sms_req_if;
    import sms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [SEL_W-1:0]         stack_sel;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output op, output stack_sel, output push_value,
                    input ready);
    modport sink   (input valid, input op, input stack_sel, input push_value,
                    output ready);
endinterface

interface sms_rsp_if;
    import sms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [FILL_W-1:0]        fill_count;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output read_value, output fill_count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input fill_count, input status,
                    output ready);
endinterface

`default_nettype wire

/* rtl/sms_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module sms_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/sms_addr_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Ring address arithmetic: y = (a + b) or (a - b), modulo TOTAL_SIZE.
// Expects a < TOTAL_SIZE and b <= TOTAL_SIZE.
module sms_addr_unit #(
    parameter int TOTAL_SIZE = 1024,
    parameter int AW         = 10,
    parameter int CW         = 11
) (
    input  logic [AW-1:0] a,
    input  logic [CW-1:0] b,
    input  logic          sub,
    output logic [AW-1:0] y
);

    localparam logic [CW:0] TOT = (CW+1)'(TOTAL_SIZE);

    logic [CW:0] ae;
    logic [CW:0] be;
    logic [CW:0] sum;
    logic [CW:0] res;

    always_comb
    begin
        ae = (CW+1)'(a);
        be = (CW+1)'(b);
        if (sub)
        begin
            sum = (ae >= be) ? ae - be : ae + TOT - be;
            res = sum;
        end
        else
        begin
            sum = ae + be;
            res = (sum >= TOT) ? sum - TOT : sum;
        end
        y = res[AW-1:0];
    end

endmodule

`default_nettype wire

/* rtl/shared_array_multi_stack_unit.sv */
// Several stacks in one circular word store; even stacks grow up, odd stacks grow down.
// Request channel (req): op, stack_sel, push_value. Response channel (rsp):
// read_value, fill_count, status; exactly one response per request transaction.
// The unit works on one request at a time and drops req.ready until it is done.
// States from acceptance to the response register, each path after S_DECODE:
//   size query, invalid stack, empty stack, memory full: S_DONE
//   pop, top: S_RD, S_DONE
//   push with room, or full and borrowing from a free partner: S_PUSH_WR, S_DONE
//   push that must shift stacks: S_WALK until room is found, then per moved stack
//   S_MV_START, S_MV_RD and S_MV_WR per word, S_MV_BASE; last S_PUSH_WR, S_DONE
// The shift is bounded by the shared ring address adder: each word is read in
// S_MV_RD and written in S_MV_WR.
// The response sits in an output register; if rsp.ready is low the next
// request is still accepted and processed, and its response waits until
// the register is taken. Reset (rst_n low, asynchronous) restores the initial
// partition of the store and empties all stacks; the store contents are not
// cleared, and no sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

module shared_array_multi_stack_unit #(
    parameter int TOTAL_SIZE = sms_pkg::DEF_TOTAL_SIZE,
    parameter int NUM_STACKS = sms_pkg::DEF_NUM_STACKS
) (
    input  logic      clk,
    input  logic      rst_n,
    sms_req_if.sink   req,
    sms_rsp_if.source rsp
);
    import sms_pkg::*;

    localparam int AW    = $clog2(TOTAL_SIZE);
    localparam int CW    = $clog2(TOTAL_SIZE + 1);
    localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int SHARE = TOTAL_SIZE / NUM_STACKS;
    localparam int REM   = TOTAL_SIZE % NUM_STACKS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_WALK,
        S_MV_START,
        S_MV_RD,
        S_MV_WR,
        S_MV_BASE,
        S_PUSH_WR,
        S_DONE
    } state_t;

    function automatic logic [AW-1:0] init_base(input int i);
        int b;
        if (i % 2 == 0)
            b = i * SHARE;
        else if (i == NUM_STACKS - 1)
            b = TOTAL_SIZE - 1;
        else
            b = (i + 1) * SHARE - 1;
        if (b < 0)
            b = b + TOTAL_SIZE;
        return AW'(b);
    endfunction

    function automatic logic [CW-1:0] init_limit(input int i);
        int l;
        l = SHARE;
        if (i == NUM_STACKS - 1)
            l = l + REM;
        return CW'(l);
    endfunction

    function automatic logic [SW-1:0] nxt_idx(input logic [SW-1:0] i);
        return (int'(i) == NUM_STACKS - 1) ? '0 : i + SW'(1);
    endfunction

    function automatic logic [SW-1:0] prv_idx(input logic [SW-1:0] i);
        return (i == '0) ? SW'(NUM_STACKS - 1) : i - SW'(1);
    endfunction

    state_t state_reg;

    logic [AW-1:0] base_reg  [NUM_STACKS];
    logic [CW-1:0] count_reg [NUM_STACKS];
    logic [CW-1:0] limit_reg [NUM_STACKS];
    logic [CW-1:0] used_reg;

    op_t               op_reg;
    logic [SEL_W-1:0]  sel_in_reg;
    logic [DATA_W-1:0] val_reg;

    logic [SW-1:0] cur_reg;
    logic [SW-1:0] end_reg;
    logic [SW-1:0] mv_reg;
    logic [AW-1:0] a_reg;
    logic [AW-1:0] wa_reg;
    logic [CW-1:0] rem_reg;

    logic [DATA_W-1:0] res_rv_reg;
    logic [CW-1:0]     res_cnt_reg;
    status_t           res_st_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_rv_reg;
    logic [FILL_W-1:0] out_cnt_reg;
    status_t           out_st_reg;

    logic [SW-1:0] s;
    logic [SW-1:0] s_nxt;
    logic [SW-1:0] s_prv;
    logic [SW-1:0] cur_nxt;
    logic          s_up;
    logic          s_full;
    logic          invalid;
    logic          all_full;

    logic [AW-1:0] ua;
    logic [CW-1:0] ub;
    logic          usub;
    logic [AW-1:0] uy;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    assign s        = sel_in_reg[SW-1:0];
    assign s_nxt    = nxt_idx(s);
    assign s_prv    = prv_idx(s);
    assign cur_nxt  = nxt_idx(cur_reg);
    assign s_up     = ~s[0];
    assign s_full   = count_reg[s] == limit_reg[s];
    assign invalid  = int'(sel_in_reg) >= NUM_STACKS;
    assign all_full = used_reg == CW'(TOTAL_SIZE);

    sms_addr_unit #(
        .TOTAL_SIZE(TOTAL_SIZE),
        .AW        (AW),
        .CW        (CW)
    ) u_addr (
        .a  (ua),
        .b  (ub),
        .sub(usub),
        .y  (uy)
    );

    sms_store #(
        .DEPTH(TOTAL_SIZE),
        .AW   (AW),
        .DW   (DATA_W)
    ) u_store (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // operand select for the shared ring adder
    always_comb
    begin
        ua   = '0;
        ub   = '0;
        usub = 1'b0;
        case (state_reg)
            S_DECODE:
            begin
                ua   = base_reg[s];
                ub   = count_reg[s] - CW'(1);
                usub = ~s_up;
            end
            S_MV_START:
            begin
                ua = base_reg[mv_reg];
                ub = mv_reg[0] ? '0 : count_reg[mv_reg] - CW'(1);
            end
            S_MV_RD:
            begin
                ua = a_reg;
                ub = CW'(1);
            end
            S_MV_WR:
            begin
                ua   = a_reg;
                ub   = CW'(1);
                usub = 1'b1;
            end
            S_MV_BASE:
            begin
                ua = base_reg[mv_reg];
                ub = CW'(1);
            end
            S_PUSH_WR:
            begin
                ua   = base_reg[s];
                ub   = count_reg[s];
                usub = ~s_up;
            end
            default:
            begin
                ua = '0;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = uy;
        mem_wdata = val_reg;
        mem_raddr = uy;
        case (state_reg)
            S_MV_RD:
            begin
                mem_raddr = a_reg;
            end
            S_MV_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = wa_reg;
                mem_wdata = mem_rdata;
            end
            S_PUSH_WR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                base_reg[i]  <= init_base(i);
                count_reg[i] <= '0;
                limit_reg[i] <= init_limit(i);
            end
        end
        else
        begin
            // S_DONE handles the output register itself
            if (rsp.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg     <= op_t'(req.op);
                        sel_in_reg <= req.stack_sel;
                        val_reg    <= req.push_value;
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    res_rv_reg  <= '0;
                    res_cnt_reg <= '0;
                    res_st_reg  <= ST_OK;
                    state_reg   <= S_DONE;
                    if (invalid)
                    begin
                        res_st_reg <= ST_INVALID;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_PUSH:
                            begin
                                if (!s_full)
                                begin
                                    state_reg <= S_PUSH_WR;
                                end
                                else if (all_full)
                                begin
                                    res_st_reg  <= ST_FULL;
                                    res_cnt_reg <= count_reg[s];
                                end
                                else if (s_up)
                                begin
                                    if (s_nxt[0])
                                    begin
                                        // partner grows down
                                        if (count_reg[s_nxt] == limit_reg[s_nxt])
                                        begin
                                            cur_reg   <= nxt_idx(s_nxt);
                                            end_reg   <= s_nxt;
                                            state_reg <= S_WALK;
                                        end
                                        else
                                        begin
                                            limit_reg[s_nxt] <= limit_reg[s_nxt] - CW'(1);
                                            limit_reg[s]     <= limit_reg[s] + CW'(1);
                                            state_reg        <= S_PUSH_WR;
                                        end
                                    end
                                    else
                                    begin
                                        // odd count: last stack wraps to stack zero
                                        cur_reg   <= s_nxt;
                                        end_reg   <= s_nxt;
                                        state_reg <= S_WALK;
                                    end
                                end
                                else
                                begin
                                    if (count_reg[s_prv] == limit_reg[s_prv])
                                    begin
                                        cur_reg   <= s_nxt;
                                        end_reg   <= s;
                                        state_reg <= S_WALK;
                                    end
                                    else
                                    begin
                                        limit_reg[s_prv] <= limit_reg[s_prv] - CW'(1);
                                        limit_reg[s]     <= limit_reg[s] + CW'(1);
                                        state_reg        <= S_PUSH_WR;
                                    end
                                end
                            end
                            OP_POP, OP_TOP:
                            begin
                                if (count_reg[s] == '0)
                                begin
                                    res_st_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            default:
                            begin
                                res_cnt_reg <= count_reg[s];
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    res_rv_reg <= mem_rdata;
                    if (op_reg == OP_POP)
                    begin
                        count_reg[s] <= count_reg[s] - CW'(1);
                        used_reg     <= used_reg - CW'(1);
                        res_cnt_reg  <= count_reg[s] - CW'(1);
                    end
                    else
                    begin
                        res_cnt_reg <= count_reg[s];
                    end
                    state_reg <= S_DONE;
                end
                S_WALK:
                begin
                    // find the first upward stack with room, or a free downward neighbor
                    if (count_reg[cur_reg] != limit_reg[cur_reg])
                    begin
                        limit_reg[cur_reg] <= limit_reg[cur_reg] - CW'(1);
                        mv_reg             <= cur_reg;
                        state_reg          <= S_MV_START;
                    end
                    else if (cur_nxt[0] && count_reg[cur_nxt] != limit_reg[cur_nxt])
                    begin
                        limit_reg[cur_nxt] <= limit_reg[cur_nxt] - CW'(1);
                        mv_reg             <= cur_reg;
                        state_reg          <= S_MV_START;
                    end
                    else if (cur_nxt[0])
                    begin
                        cur_reg <= nxt_idx(cur_nxt);
                    end
                    else
                    begin
                        cur_reg <= cur_nxt;
                    end
                end
                S_MV_START:
                begin
                    if (count_reg[mv_reg] == '0)
                    begin
                        state_reg <= S_MV_BASE;
                    end
                    else
                    begin
                        a_reg     <= uy;
                        rem_reg   <= count_reg[mv_reg];
                        state_reg <= S_MV_RD;
                    end
                end
                S_MV_RD:
                begin
                    wa_reg    <= uy;
                    state_reg <= S_MV_WR;
                end
                S_MV_WR:
                begin
                    a_reg   <= uy;
                    rem_reg <= rem_reg - CW'(1);
                    if (rem_reg == CW'(1))
                    begin
                        state_reg <= S_MV_BASE;
                    end
                    else
                    begin
                        state_reg <= S_MV_RD;
                    end
                end
                S_MV_BASE:
                begin
                    base_reg[mv_reg] <= uy;
                    if (mv_reg == end_reg)
                    begin
                        limit_reg[s] <= limit_reg[s] + CW'(1);
                        state_reg    <= S_PUSH_WR;
                    end
                    else
                    begin
                        mv_reg    <= prv_idx(mv_reg);
                        state_reg <= S_MV_START;
                    end
                end
                S_PUSH_WR:
                begin
                    count_reg[s] <= count_reg[s] + CW'(1);
                    used_reg     <= used_reg + CW'(1);
                    res_cnt_reg  <= count_reg[s] + CW'(1);
                    res_st_reg   <= ST_OK;
                    res_rv_reg   <= '0;
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_rv_reg    <= res_rv_reg;
                        out_cnt_reg   <= FILL_W'(res_cnt_reg);
                        out_st_reg    <= res_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready      = state_reg == S_IDLE;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_rv_reg;
    assign rsp.fill_count = out_cnt_reg;
    assign rsp.status     = out_st_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(TOTAL_SIZE))
        else $error("word usage count exceeds store size");

    a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MV_RD || state_reg == S_MV_WR) |-> rem_reg != '0)
        else $error("word move running with nothing left to move");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous one in progress");

    a_done_leads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished transaction not presented");
`endif

endmodule

`default_nettype wire
